// File: hdl/sblru_pkg.sv
package sblru_pkg;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_TOUCH  = 1'b1;

   localparam logic [2:0] ST_EVICT  = 3'd0;
   localparam logic [2:0] ST_INSERT = 3'd1;
   localparam logic [2:0] ST_REJECT = 3'd2;
   localparam logic [2:0] ST_TOUCH  = 3'd3;
   localparam logic [2:0] ST_MISS   = 3'd4;

   localparam int KEY_W = 16;

   typedef struct packed {
      logic latch;
      logic evict;
      logic append;
      logic move;
      logic scan_clr;
      logic scan_inc;
   } dp_cmd_type;

   typedef struct packed {
      logic              func;
      logic              reject;
      logic              need_evict;
      logic              scan_end;
      logic              scan_hit;
      logic [KEY_W-1:0]  evict_key;
      logic [KEY_W-1:0]  req_key;
   } dp_stat_type;

endpackage

// File: hdl/sblru_datapath.sv
module sblru_datapath #(
   parameter int SLOTS    = 32,
   parameter int KEY_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic [31:0]                 csr_write_data,
   input  logic                        req_func,
   input  logic [sblru_pkg::KEY_W-1:0] req_key,
   input  logic [31:0]                 req_entry_size,
   input  logic [31:0]                 req_time_stamp,
   input  sblru_pkg::dp_cmd_type       cmd,
   output sblru_pkg::dp_stat_type      stat
);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int KW = sblru_pkg::KEY_W;

   logic [31:0]   cap_ff;
   logic [CW-1:0] held_ff;
   logic [31:0]   used_ff;
   logic [31:0]   last_stamp_ff;
   logic          func_ff;
   logic [KW-1:0] key_ff;
   logic [31:0]   size_ff;
   logic [31:0]   stamp_ff;
   logic [CW-1:0] scan_ff;

   logic [KW-1:0] slot_key   [SLOTS];
   logic [31:0]   slot_size  [SLOTS];
   logic [31:0]   slot_stamp [SLOTS];

   logic [KW-1:0] key_mask;
   logic [IW-1:0] scan_idx;
   logic [CW-1:0] held_m1;
   logic [32:0]   need_total;
   logic [31:0]   used_base;

   always_comb begin
      for (int i = 0; i < KW; i++) begin
         key_mask[i] = (i < KEY_BITS);
      end
   end

   assign scan_idx   = scan_ff[IW-1:0];
   assign held_m1    = held_ff - CW'(1);
   assign need_total = {1'b0, used_ff} + {1'b0, size_ff};
   assign used_base  = (held_ff == '0) ? 32'd0 : used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= 32'd65536;
         held_ff <= '0;
         used_ff <= '0;
         scan_ff <= '0;
      end else begin
         if (csr_write_en) begin
            cap_ff <= csr_write_data;
         end
         if (cmd.evict) begin
            held_ff <= held_m1;
            used_ff <= used_ff - slot_size[0];
         end else if (cmd.append) begin
            held_ff <= held_ff + CW'(1);
            used_ff <= used_base + size_ff;
         end
         if (cmd.scan_clr) begin
            scan_ff <= '0;
         end else if (cmd.scan_inc) begin
            scan_ff <= scan_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff  <= req_func;
         key_ff   <= req_key & key_mask;
         size_ff  <= req_entry_size;
         stamp_ff <= req_time_stamp;
      end
      if (cmd.append || cmd.move) begin
         last_stamp_ff <= stamp_ff;
      end
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_slot
      always_ff @(posedge clock) begin
         if ((cmd.append && held_ff == CW'(g)) || (cmd.move && held_m1 == CW'(g))) begin
            slot_key[g]   <= key_ff;
            slot_size[g]  <= cmd.move ? slot_size[scan_idx] : size_ff;
            slot_stamp[g] <= stamp_ff;
         end else if (cmd.evict || (cmd.move && CW'(g) >= scan_ff)) begin
            if (g < SLOTS - 1) begin
               slot_key[g]   <= slot_key[(g < SLOTS - 1) ? g + 1 : g];
               slot_size[g]  <= slot_size[(g < SLOTS - 1) ? g + 1 : g];
               slot_stamp[g] <= slot_stamp[(g < SLOTS - 1) ? g + 1 : g];
            end
         end
      end
   end

   always_comb begin
      stat.func       = func_ff;
      stat.reject     = (size_ff >= cap_ff) ||
                        ((held_ff != '0) && (last_stamp_ff > stamp_ff));
      stat.need_evict = (held_ff != '0) &&
                        ((need_total > {1'b0, cap_ff}) || (held_ff >= CW'(SLOTS)));
      stat.scan_end   = scan_ff >= held_ff;
      stat.scan_hit   = slot_key[scan_idx] == key_ff;
      stat.evict_key  = slot_key[0];
      stat.req_key    = key_ff;
   end

   held_in_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CW'(SLOTS))
      else $error("held count above slot count");
   evict_decrements: assert property (@(posedge clock) disable iff (reset)
      cmd.evict |=> held_ff == $past(held_m1))
      else $error("eviction did not drop one entry");
   append_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> held_ff < CW'(SLOTS))
      else $error("append with all slots full");

endmodule

// File: hdl/sblru_ctrl.sv
module sblru_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_status,
   output logic [sblru_pkg::KEY_W-1:0] rsp_result_key,
   output logic                        rsp_last,
   input  sblru_pkg::dp_stat_type      stat,
   output sblru_pkg::dp_cmd_type       cmd
);
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECIDE = 2'd1;
   localparam logic [1:0] S_EVICT  = 2'd2;
   localparam logic [1:0] S_SCAN   = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [sblru_pkg::KEY_W-1:0] rsp_key_ff;
   logic        rsp_last_ff;
   logic        free;
   logic        emit;
   logic [2:0]  emit_status;
   logic        emit_last;
   logic [sblru_pkg::KEY_W-1:0] emit_key;

   assign free      = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      emit        = 1'b0;
      emit_status = sblru_pkg::ST_INSERT;
      emit_last   = 1'b1;
      emit_key    = stat.req_key;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.func == sblru_pkg::FUNC_TOUCH) begin
               cmd.scan_clr = 1'b1;
               state_in     = S_SCAN;
            end else if (!stat.reject) begin
               state_in = S_EVICT;
            end else if (free) begin
               emit        = 1'b1;
               emit_status = sblru_pkg::ST_REJECT;
               state_in    = S_IDLE;
            end
         end
         S_EVICT: begin
            if (free) begin
               emit = 1'b1;
               if (stat.need_evict) begin
                  cmd.evict   = 1'b1;
                  emit_status = sblru_pkg::ST_EVICT;
                  emit_key    = stat.evict_key;
                  emit_last   = 1'b0;
               end else begin
                  cmd.append = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         S_SCAN: begin
            if (stat.scan_end) begin
               if (free) begin
                  emit        = 1'b1;
                  emit_status = sblru_pkg::ST_MISS;
                  state_in    = S_IDLE;
               end
            end else if (stat.scan_hit) begin
               if (free) begin
                  cmd.move    = 1'b1;
                  emit        = 1'b1;
                  emit_status = sblru_pkg::ST_TOUCH;
                  state_in    = S_IDLE;
               end
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_key_ff    <= emit_key;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_result_key = rsp_key_ff;
   assign rsp_last       = rsp_last_ff;

   no_emit_when_busy: assert property (@(posedge clock) disable iff (reset)
      emit |-> free)
      else $error("result overwrote a pending item");
   evict_only_needed: assert property (@(posedge clock) disable iff (reset)
      cmd.evict |-> stat.need_evict && state_ff == S_EVICT)
      else $error("eviction without need");
   move_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.move |-> stat.scan_hit && !stat.scan_end)
      else $error("move without a key match");

endmodule

// File: hdl/size_budget_lru_cache.sv
// Size-budget LRU cache.
// Input channel req_*: one item is an insert (req_func 0) or a touch (1) of
// req_key; inserts carry req_entry_size and every item carries a time stamp.
// Result channel rsp_*: one or more items per request, rsp_last on the final.
// Inserts give zero or more evictions (oldest first), then inserted, or a
// single rejected. Touches give touched or touch missed.
// csr_write_en/csr_write_data set the size budget; write only while idle.
// Sequence: a request is taken only in the idle state. A rejected insert
// is answered from the decide state; an accepted insert emits one eviction
// per step in the evict state, then inserts; a touch scans the held slots
// from the oldest until a key match or the end. The controller then goes
// back to idle, where the next request is taken.
// The result register reloads in the cycle its item is taken. While an item
// waits without rsp_ready, the controller holds before its next result.
// Reset empties the list, clears the used total and sets the budget to
// 65536; no clearing pass is needed.
module size_budget_lru_cache #(
   parameter int SLOTS    = 32,
   parameter int KEY_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [15:0] req_key,
   input  logic [31:0] req_entry_size,
   input  logic [31:0] req_time_stamp,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_result_key,
   output logic        rsp_last
);
   sblru_pkg::dp_cmd_type  cmd;
   sblru_pkg::dp_stat_type stat;

   sblru_datapath #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_func       (req_func),
      .req_key        (req_key),
      .req_entry_size (req_entry_size),
      .req_time_stamp (req_time_stamp),
      .cmd            (cmd),
      .stat           (stat)
   );

   sblru_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_result_key (rsp_result_key),
      .rsp_last       (rsp_last),
      .stat           (stat),
      .cmd            (cmd)
   );

endmodule

// File: bench/tb.sv
module tb;

   localparam int NSLOT = 32;
   localparam int N_RANDOM = 240;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = sblru_pkg::FUNC_INSERT;
   logic [15:0] req_key = '0;
   logic [31:0] req_entry_size = '0;
   logic [31:0] req_time_stamp = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_result_key;
   logic        rsp_last;

   size_budget_lru_cache i_dut (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_key(req_key), .req_entry_size(req_entry_size),
      .req_time_stamp(req_time_stamp),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_result_key(rsp_result_key), .rsp_last(rsp_last)
   );

   always #2 clock = ~clock;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] rkey;
      logic        last;
   } outcome_type;

   typedef struct {
      logic        func;
      logic [15:0] rkey;
      logic [31:0] size;
      logic [31:0] stamp;
      logic        typed;
      logic [2:0]  status;
   } stim_row_type;

   // cache shadow, oldest first
   logic [15:0] c_key[NSLOT];
   logic [31:0] c_size[NSLOT];
   logic [31:0] c_stamp[NSLOT];
   int          c_count;
   logic [31:0] c_used;
   logic [31:0] budget;

   outcome_type expected_q[$];
   int       mismatches = 0;
   int       sender_idle = 20;
   int       receiver_idle = 71;
   bit       hold_off = 1'b0;

   function automatic void push_outcome(logic [2:0] st, logic [15:0] k);
      outcome_type o;
      o.status = st;
      o.rkey = k;
      o.last = 1'b0;
      expected_q = {expected_q, o};
   endfunction

   function automatic void remove_slot(int idx);
      for (int i = idx; i + 1 < c_count; i++) begin
         c_key[i] = c_key[i+1];
         c_size[i] = c_size[i+1];
         c_stamp[i] = c_stamp[i+1];
      end
      c_count--;
   endfunction

   function automatic void add_slot(logic [15:0] k, logic [31:0] s, logic [31:0] t);
      c_key[c_count] = k;
      c_size[c_count] = s;
      c_stamp[c_count] = t;
      c_count++;
   endfunction

   function automatic void predict_cache(logic f, logic [15:0] k, logic [31:0] s,
                                         logic [31:0] t);
      int hit;
      logic [31:0] sz;
      if (f == sblru_pkg::FUNC_INSERT) begin
         if (s >= budget || (c_count > 0 && c_stamp[c_count-1] > t)) begin
            push_outcome(sblru_pkg::ST_REJECT, k);
         end else begin
            while (c_count > 0 && (c_used > budget || s > budget - c_used ||
                   c_count >= NSLOT)) begin
               push_outcome(sblru_pkg::ST_EVICT, c_key[0]);
               c_used -= c_size[0];
               remove_slot(0);
            end
            if (c_count == 0) c_used = '0;
            add_slot(k, s, t);
            c_used += s;
            push_outcome(sblru_pkg::ST_INSERT, k);
         end
      end else begin
         hit = -1;
         for (int i = 0; i < c_count; i++) begin
            if (hit < 0 && c_key[i] == k) hit = i;
         end
         if (hit >= 0) begin
            sz = c_size[hit];
            remove_slot(hit);
            add_slot(k, sz, t);
            push_outcome(sblru_pkg::ST_TOUCH, k);
         end else begin
            push_outcome(sblru_pkg::ST_MISS, k);
         end
      end
      expected_q[$].last = 1'b1;
   endfunction

   task automatic send_item(logic f, logic [15:0] k, logic [31:0] s, logic [31:0] t);
      while ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_key <= k;
      req_entry_size <= s;
      req_time_stamp <= t;
      predict_cache(f, k, s, t);
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() > 0) @(negedge clock);
      repeat (NSLOT + 8) @(negedge clock);
   endtask

   task automatic set_budget(logic [31:0] v);
      drain();
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      budget = v;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= receiver_idle);
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: status %0d key %h last %b",
                        rsp_status, rsp_result_key, rsp_last);
         end else begin
            want = expected_q[0];
            expected_q.delete(0);
            if (want.status !== rsp_status || want.rkey !== rsp_result_key ||
                want.last !== rsp_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp status %0d key %h last %b, got %0d %h %b",
                           want.status, want.rkey, want.last,
                           rsp_status, rsp_result_key, rsp_last);
            end
         end
      end
   end

   stim_row_type directed[$];

   function automatic void add_row(logic f, logic [15:0] k, logic [31:0] s,
                                   logic [31:0] t, logic typed, logic [2:0] st);
      stim_row_type r;
      r.func = f; r.rkey = k; r.size = s; r.stamp = t;
      r.typed = typed; r.status = st;
      directed = {directed, r};
   endfunction

   task automatic run_random(int n, int key_span);
      logic [31:0] t;
      logic [31:0] s;
      t = $urandom_range(1000);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) t = $urandom();
         else t = t + $urandom_range(3);
         case ($urandom_range(5))
            0: s = $urandom();
            1: s = budget == 0 ? 32'd0 : budget - 1;
            default: s = $urandom_range(budget / 4 + 1);
         endcase
         if ($urandom_range(2) == 0)
            send_item(sblru_pkg::FUNC_TOUCH, 16'($urandom_range(key_span)), $urandom(), t);
         else
            send_item(sblru_pkg::FUNC_INSERT, 16'($urandom_range(key_span)), s, t);
      end
   endtask

   initial begin
      c_count = 0;
      c_used = '0;
      budget = 32'd65536;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      add_row(sblru_pkg::FUNC_TOUCH,  16'h0000, 32'd0,        32'd0,        1'b1,
              sblru_pkg::ST_MISS);
      add_row(sblru_pkg::FUNC_INSERT, 16'hffff, 32'd65536,    32'd10,       1'b1,
              sblru_pkg::ST_REJECT);
      add_row(sblru_pkg::FUNC_INSERT, 16'hffff, 32'hffffffff, 32'd10,       1'b1,
              sblru_pkg::ST_REJECT);
      add_row(sblru_pkg::FUNC_INSERT, 16'h0001, 32'd0,        32'd100,      1'b0,
              sblru_pkg::ST_INSERT);
      add_row(sblru_pkg::FUNC_INSERT, 16'h0002, 32'd65535,    32'd100,      1'b0,
              sblru_pkg::ST_INSERT);
      add_row(sblru_pkg::FUNC_INSERT, 16'h0003, 32'd1,        32'd99,       1'b1,
              sblru_pkg::ST_REJECT);
      add_row(sblru_pkg::FUNC_INSERT, 16'h0001, 32'd30000,    32'd200,      1'b0,
              sblru_pkg::ST_INSERT);
      add_row(sblru_pkg::FUNC_TOUCH,  16'h0001, 32'hffffffff, 32'd0,        1'b0,
              sblru_pkg::ST_TOUCH);
      add_row(sblru_pkg::FUNC_TOUCH,  16'h0002, 32'd0,        32'd5,        1'b0,
              sblru_pkg::ST_TOUCH);
      add_row(sblru_pkg::FUNC_INSERT, 16'h0004, 32'd40000,    32'd5,        1'b0,
              sblru_pkg::ST_INSERT);
      add_row(sblru_pkg::FUNC_INSERT, 16'h0005, 32'd0,        32'hffffffff, 1'b0,
              sblru_pkg::ST_INSERT);
      add_row(sblru_pkg::FUNC_TOUCH,  16'hffff, 32'd0,        32'hffffffff, 1'b0,
              sblru_pkg::ST_MISS);
      for (int i = 0; i < 34; i++)
         add_row(sblru_pkg::FUNC_INSERT, 16'(i * 1927), 32'd1, 32'hffffffff, 1'b0,
                 sblru_pkg::ST_INSERT);
      foreach (directed[i]) begin
         send_item(directed[i].func, directed[i].rkey, directed[i].size,
                   directed[i].stamp);
         if (directed[i].typed && expected_q.size() == 1 &&
             expected_q[0].status !== directed[i].status) begin
            mismatches++;
            $display("row %0d: predictor disagrees with table", i);
         end
      end

      set_budget(32'd0);
      send_item(sblru_pkg::FUNC_INSERT, 16'h0007, 32'd0, 32'hffffffff);
      set_budget(32'd1);
      send_item(sblru_pkg::FUNC_INSERT, 16'h0008, 32'd0, 32'hffffffff);
      set_budget(32'hffffffff);
      run_random(N_RANDOM / 3, 15);

      // stall the receiver while requests keep arriving
      fork
         begin
            hold_off = 1'b1;
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end
         run_random(20, 7);
      join

      sender_idle = 71;
      receiver_idle = 20;
      set_budget(32'd1000);
      run_random(N_RANDOM / 3, 40);
      set_budget(32'd100);
      run_random(20, 40);

      sender_idle = 0;
      receiver_idle = 0;
      set_budget(32'd65536);
      run_random(N_RANDOM / 3, 63);
      drain();

      if (mismatches == 0 && expected_q.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: sim.f
hdl/sblru_pkg.sv
hdl/sblru_datapath.sv
hdl/sblru_ctrl.sv
hdl/size_budget_lru_cache.sv
bench/tb.sv
